@@ hdl/jssl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssl_pkg: shared types and constants of the joint setpoint slew limiter
// Holds the transaction payload structs, the action and register codes,
// the register reset values, the sequencer state type and its control struct.
// ----------------------------------------------------------------------------
package jssl_pkg;

	localparam int SLOT_W = 4;
	localparam int VALUE_W = 32;
	localparam int WEIGHT_W = 17;
	localparam int PERIOD_W = 17;
	localparam int BASE_W = 31;
	localparam int TICK_W = 16;
	localparam int MASK_W = 16;
	localparam int MAX_SLOTS = 16;

	// Action codes of an input item.
	localparam logic [1:0] ACT_FEEDBACK = 2'd0;
	localparam logic [1:0] ACT_TARGET = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE_MASK = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BASE_STEP = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_PERIOD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_FADE_INC = 3'd4;

	// Register reset values.
	localparam logic [MASK_W-1:0] RST_ENABLE_MASK = 16'd0;
	localparam logic [BASE_W-1:0] RST_BASE_STEP = 31'd1311;
	localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD = 17'd655;
	localparam logic [TICK_W-1:0] RST_TIMEOUT = 16'd50;
	localparam logic [PERIOD_W-1:0] RST_FADE_INC = 17'd655;

	localparam logic [TICK_W-1:0] TICKS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0] action;
		logic [SLOT_W-1:0] joint;
		logic signed [VALUE_W-1:0] position;
		logic signed [VALUE_W-1:0] velocity;
		logic final_feedback;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic signed [VALUE_W-1:0] command_position;
		logic signed [VALUE_W-1:0] command_velocity;
		logic [WEIGHT_W-1:0] fade_weight;
		logic final_command;
	} result_t;

	typedef struct packed {
		logic [MASK_W-1:0] joint_enable_mask;
		logic [BASE_W-1:0] base_max_step;
		logic [PERIOD_W-1:0] step_period;
		logic [TICK_W-1:0] timeout_ticks;
		logic [PERIOD_W-1:0] fade_increment;
	} cfg_regs_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_LIMIT,
		ST_MOVE,
		ST_EMIT
	} seq_state_t;

	// Strobes from the sequencer to the step unit and the storage.
	typedef struct packed {
		logic busy;
		logic load;
		logic mul;
		logic limit;
		logic move;
		logic emit;
		logic final_cmd;
	} seq_ctrl_t;

endpackage

@@ hdl/jssl_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssl_cfg: configuration register file
// Holds the five control registers, masks written data to each register's
// width and ignores writes to indexes beyond the list.
// ----------------------------------------------------------------------------
module jssl_cfg
	import jssl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [31:0] wr_data,
	output cfg_regs_t regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.joint_enable_mask <= RST_ENABLE_MASK;
			regs_q.base_max_step <= RST_BASE_STEP;
			regs_q.step_period <= RST_STEP_PERIOD;
			regs_q.timeout_ticks <= RST_TIMEOUT;
			regs_q.fade_increment <= RST_FADE_INC;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ENABLE_MASK: regs_q.joint_enable_mask <= wr_data[MASK_W-1:0];
				CFG_BASE_STEP:   regs_q.base_max_step <= wr_data[BASE_W-1:0];
				CFG_STEP_PERIOD: regs_q.step_period <= wr_data[PERIOD_W-1:0];
				CFG_TIMEOUT:     regs_q.timeout_ticks <= wr_data[TICK_W-1:0];
				CFG_FADE_INC:    regs_q.fade_increment <= wr_data[PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

@@ hdl/jssl_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssl_step: shared step arithmetic unit
// Forms the per-slot step limit from the target velocity and moves the
// command toward the target by at most that limit, one operation per cycle.
// ----------------------------------------------------------------------------
module jssl_step
	import jssl_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  seq_ctrl_t ctrl,
	input  logic signed [VALUE_W-1:0] velocity,
	input  logic signed [VALUE_W-1:0] target,
	input  logic signed [VALUE_W-1:0] current,
	input  logic [PERIOD_W-1:0] step_period,
	input  logic [BASE_W-1:0] base_max_step,
	output logic signed [VALUE_W-1:0] next_position,
	output logic signed [VALUE_W-1:0] velocity_out
);

	localparam int PROD_W = VALUE_W + PERIOD_W;
	localparam int TRIPLE_W = PROD_W + 2;
	localparam int DIFF_W = VALUE_W + 1;

	logic [VALUE_W-1:0] mag_q;
	logic signed [VALUE_W-1:0] vel_q;
	logic signed [VALUE_W-1:0] tgt_q;
	logic signed [VALUE_W-1:0] cur_q;
	logic [PROD_W-1:0] prod_q;
	logic [TRIPLE_W-1:0] maxd_q;
	logic signed [VALUE_W-1:0] next_q;

	logic [TRIPLE_W-1:0] triple;
	logic [TRIPLE_W-1:0] vterm;
	logic [TRIPLE_W-1:0] base_ext;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W:0] diff_x;
	logic signed [DIFF_W:0] maxd_lo;
	logic limit_big;
	logic signed [VALUE_W-1:0] next_val;

	// Three times the product, then the Q-format shift with one more bit for
	// the halving of 1.5.
	assign triple = {2'b00, prod_q} + {1'b0, prod_q, 1'b0};
	assign vterm = triple >> (FRACTION_BITS + 1);
	assign base_ext = TRIPLE_W'(base_max_step);

	assign diff = DIFF_W'(tgt_q) - DIFF_W'(cur_q);
	assign diff_x = (DIFF_W + 1)'(diff);
	// A limit at or above 2^33 always reaches the target.
	assign limit_big = |maxd_q[TRIPLE_W-1:DIFF_W];
	assign maxd_lo = $signed({1'b0, maxd_q[DIFF_W-1:0]});

	always_comb begin
		next_val = tgt_q;
		if (!limit_big) begin
			if (diff_x > maxd_lo) begin
				next_val = cur_q + $signed(maxd_q[VALUE_W-1:0]);
			end else if (diff_x < -maxd_lo) begin
				next_val = cur_q - $signed(maxd_q[VALUE_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= velocity[VALUE_W-1] ? VALUE_W'(-velocity) : VALUE_W'(velocity);
			vel_q <= velocity;
			tgt_q <= target;
			cur_q <= current;
		end
		if (ctrl.mul) begin
			prod_q <= PROD_W'(mag_q) * PROD_W'(step_period);
		end
		if (ctrl.limit) begin
			maxd_q <= (vterm > base_ext) ? vterm : base_ext;
		end
		if (ctrl.move) begin
			next_q <= next_val;
		end
	end

	assign next_position = next_q;
	assign velocity_out = vel_q;

endmodule

@@ hdl/jssl_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssl_seq: tick sequencer
// Walks the joint slots once per control tick and drives the step unit
// through load, multiply, limit, move and emit for each active slot.
// ----------------------------------------------------------------------------
module jssl_seq
	import jssl_pkg::*;
#(
	parameter int SLOTS = 16,
	parameter int SLOT_IDX_W = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [SLOTS-1:0] active,
	input  logic out_free,
	output logic [SLOT_IDX_W-1:0] slot,
	output seq_ctrl_t ctrl
);

	seq_state_t state_q, state_d;
	logic [SLOT_IDX_W-1:0] slot_q;
	logic last_slot;
	logic more_above;

	assign last_slot = (slot_q == SLOT_IDX_W'(SLOTS - 1));

	always_comb begin
		more_above = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if ((SLOT_IDX_W'(i) > slot_q) && active[i]) begin
				more_above = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (active[slot_q]) begin
					state_d = ST_MUL;
				end else if (last_slot) begin
					state_d = ST_IDLE;
				end
			end
			ST_MUL:   state_d = ST_LIMIT;
			ST_LIMIT: state_d = ST_MOVE;
			ST_MOVE:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = last_slot ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.busy = (state_q != ST_IDLE);
		ctrl.final_cmd = !more_above;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_SCAN:  ctrl.load = active[slot_q];
			ST_MUL:   ctrl.mul = 1'b1;
			ST_LIMIT: ctrl.limit = 1'b1;
			ST_MOVE:  ctrl.move = 1'b1;
			ST_EMIT:  ctrl.emit = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				slot_q <= '0;
			end else if ((state_q == ST_SCAN && !active[slot_q] && !last_slot) ||
					(state_q == ST_EMIT && out_free && !last_slot)) begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	assign slot = slot_q;

endmodule

@@ hdl/joint_setpoint_slew_limiter_fade.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_setpoint_slew_limiter_fade: multi-joint setpoint ramp with fade
// Ramps each enabled joint's position command toward its target by a
// velocity-dependent step per control tick, and fades a command authority
// weight in or out depending on how recently a target arrived.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_ready    item_t   (action, joint, ...)
// result    out        result_valid / result_ready result_t (slot, command, ...)
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A feedback or target transaction leaves item_ready high. A tick transaction
// holds item_ready low while the sequencer walks the slots: an inactive slot
// passes through the scan step only, an active slot through scan, multiply,
// limit, move and emit. The single multiplier in the step unit and the
// one-slot-at-a-time walk set the length of a tick.
// A result waiting in the output register stalls only the emit step.
// Reset clears control state and the registers; there is no clearing pass.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module joint_setpoint_slew_limiter_fade
	import jssl_pkg::*;
#(
	parameter int JOINT_SLOTS = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  item_t item,
	output logic result_valid,
	input  logic result_ready,
	output result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);

	// Only slots addressable by the joint field are ever used.
	localparam int SLOTS = (JOINT_SLOTS < MAX_SLOTS) ? JOINT_SLOTS : MAX_SLOTS;
	localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	// The weight must hold 1.0 in the chosen fraction format.
	localparam int W_W = (FRACTION_BITS + 1 > WEIGHT_W) ? FRACTION_BITS + 1 : WEIGHT_W;
	localparam logic [W_W:0] WEIGHT_ONE = (W_W + 1)'(1) << FRACTION_BITS;

	cfg_regs_t cfg;
	seq_ctrl_t ctrl;
	logic [SLOT_IDX_W-1:0] seq_slot;

	// Per-slot storage. Commands and targets have no reset; the velocity
	// reads as zero until a target transaction writes it.
	logic signed [VALUE_W-1:0] cur_cmd_q [SLOTS];
	logic signed [VALUE_W-1:0] tgt_pos_q [SLOTS];
	logic signed [VALUE_W-1:0] tgt_vel_q [SLOTS];
	logic [SLOTS-1:0] vel_written_q;
	logic [SLOTS-1:0] tgt_valid_q;

	logic initialized_q;
	logic [TICK_W-1:0] ticks_q;
	logic [W_W-1:0] weight_q;

	logic result_valid_q;
	result_t result_q;

	logic item_fire;
	logic joint_enabled;
	logic [SLOT_IDX_W-1:0] joint_idx;
	logic do_feedback;
	logic do_target;
	logic do_tick;
	logic [SLOTS-1:0] active;
	logic out_free;
	logic signed [VALUE_W-1:0] rd_vel;
	logic [W_W:0] weight_sum;
	logic [W_W-1:0] weight_up;
	logic [W_W-1:0] weight_dn;
	logic [W_W-1:0] inc_ext;
	logic signed [VALUE_W-1:0] next_position;
	logic signed [VALUE_W-1:0] step_velocity;

	jssl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (cfg)
	);

	assign cfg_ready = 1'b1;

	assign item_ready = !ctrl.busy;
	assign item_fire = item_valid && item_ready;

	// A joint beyond the implemented slots is never enabled.
	assign joint_idx = item.joint[SLOT_IDX_W-1:0];
	assign joint_enabled = ({1'b0, item.joint} < (SLOT_W + 1)'(SLOTS)) &&
		cfg.joint_enable_mask[item.joint];

	assign do_feedback = item_fire && (item.action == ACT_FEEDBACK) && !initialized_q;
	assign do_target = item_fire && (item.action == ACT_TARGET) && initialized_q;
	assign do_tick = item_fire && (item.action == ACT_TICK) && initialized_q;

	assign active = cfg.joint_enable_mask[SLOTS-1:0] & tgt_valid_q;
	assign out_free = !result_valid_q || result_ready;

	jssl_seq #(
		.SLOTS      (SLOTS),
		.SLOT_IDX_W (SLOT_IDX_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (do_tick),
		.active   (active),
		.out_free (out_free),
		.slot     (seq_slot),
		.ctrl     (ctrl)
	);

	assign rd_vel = vel_written_q[seq_slot] ? tgt_vel_q[seq_slot] : '0;

	jssl_step #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_step (
		.clk           (clk),
		.ctrl          (ctrl),
		.velocity      (rd_vel),
		.target        (tgt_pos_q[seq_slot]),
		.current       (cur_cmd_q[seq_slot]),
		.step_period   (cfg.step_period),
		.base_max_step (cfg.base_max_step),
		.next_position (next_position),
		.velocity_out  (step_velocity)
	);

	// Fade weight: ramp up while a target is recent, down otherwise,
	// clamped to zero and to 1.0.
	assign inc_ext = W_W'(cfg.fade_increment);
	assign weight_sum = (W_W + 1)'(weight_q) + (W_W + 1)'(cfg.fade_increment);
	assign weight_up = (weight_sum > WEIGHT_ONE) ? W_W'(WEIGHT_ONE) : W_W'(weight_sum);
	assign weight_dn = (weight_q > inc_ext) ? (weight_q - inc_ext) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initialized_q <= 1'b0;
			ticks_q <= TICKS_MAX;
			weight_q <= '0;
			tgt_valid_q <= '0;
			vel_written_q <= '0;
		end else begin
			if (do_feedback) begin
				if (item.final_feedback) begin
					initialized_q <= 1'b1;
				end
				if (joint_enabled) begin
					tgt_valid_q[joint_idx] <= 1'b1;
				end
			end
			if (do_target) begin
				ticks_q <= '0;
				if (joint_enabled) begin
					tgt_valid_q[joint_idx] <= 1'b1;
					vel_written_q[joint_idx] <= 1'b1;
				end
			end
			if (do_tick) begin
				weight_q <= (ticks_q < cfg.timeout_ticks) ? weight_up : weight_dn;
				if (ticks_q != TICKS_MAX) begin
					ticks_q <= ticks_q + 1'b1;
				end
			end
		end
	end

	// Slot storage. Item writes and the sequencer's command write-back never
	// coincide, since items are only taken while the sequencer is idle.
	always_ff @(posedge clk) begin
		if (do_feedback && joint_enabled) begin
			cur_cmd_q[joint_idx] <= item.position;
			tgt_pos_q[joint_idx] <= item.position;
		end
		if (do_target && joint_enabled) begin
			tgt_pos_q[joint_idx] <= item.position;
			tgt_vel_q[joint_idx] <= item.velocity;
		end
		if (ctrl.emit) begin
			cur_cmd_q[seq_slot] <= next_position;
		end
	end

	// Output register: one result transaction per moved slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result_q.slot <= SLOT_W'(seq_slot);
			result_q.command_position <= next_position;
			result_q.command_velocity <= step_velocity;
			result_q.fade_weight <= weight_q[WEIGHT_W-1:0];
			result_q.final_command <= ctrl.final_cmd;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

@@ hdl/jssl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssl_port_checks: port-level checks for the slew limiter
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module jssl_port_checks
	import jssl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_ready,
	input  item_t item,
	input  logic result_valid,
	input  logic result_ready,
	input  result_t result,
	input  logic cfg_valid,
	input  logic cfg_ready
);

	// A stalled result transaction holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// The configuration port never pushes back.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

	// Feedback, target and unused-code transactions never make the block busy.
	a_short_items: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item.action != ACT_TICK) |=> item_ready)
		else $error("block busy after a non-tick transaction");

	// A new result only appears while a tick is being walked.
	a_result_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result produced outside a tick");

endmodule

bind joint_setpoint_slew_limiter_fade jssl_port_checks u_jssl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

@@ bench/jssl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssl_checker: joint command predictor and scoreboard for the slew limiter
// Watches the item, result and register channels. It keeps its own copy of
// the ramp state and of the registers, and compares each joint command
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module jssl_checker
	import jssl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_ready,
	input  item_t item,
	input  logic result_valid,
	input  logic result_ready,
	input  result_t result,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int mismatches,
	output int outstanding,
	output int commands_checked
);
	localparam int FRAC = 16;
	localparam int SHOWN_MAX = 40;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;

	cfg_regs_t regs;
	logic initialized;
	logic signed [VALUE_W-1:0] command_q [MAX_SLOTS];
	logic signed [VALUE_W-1:0] goal_pos [MAX_SLOTS];
	logic signed [VALUE_W-1:0] goal_vel [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] goal_set;
	logic [TICK_W-1:0] ticks_since;
	logic [WEIGHT_W-1:0] weight;
	result_t queued_commands [$];
	int error_total = 0;
	int compared = 0;

	task automatic report_mismatch(input string what, input longint got,
		input longint want);
		if (error_total < SHOWN_MAX)
			$display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
		error_total++;
	endtask

	// One control tick: fade update, counter update, then the slot walk.
	task automatic ramp_tick();
		logic [WEIGHT_W:0] raised;
		logic [MAX_SLOTS-1:0] moving;
		int last_slot;
		longint vel, mag, vterm, base, period, limit, diff, nxt, cur, goal;
		result_t cmd;
		raised = weight + regs.fade_increment;
		if (ticks_since < regs.timeout_ticks)
			weight = (raised > WEIGHT_ONE) ? WEIGHT_ONE : raised[WEIGHT_W-1:0];
		else
			weight = (weight > regs.fade_increment) ? weight - regs.fade_increment : '0;
		if (ticks_since != TICKS_MAX)
			ticks_since++;
		moving = regs.joint_enable_mask & goal_set;
		last_slot = -1;
		for (int s = 0; s < MAX_SLOTS; s++)
			if (moving[s])
				last_slot = s;
		period = regs.step_period;
		base = regs.base_max_step;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (moving[s]) begin
				vel = goal_vel[s];
				mag = (vel < 0) ? -vel : vel;
				vterm = (mag * period * 3) >>> (FRAC + 1);
				limit = (vterm > base) ? vterm : base;
				cur = command_q[s];
				goal = goal_pos[s];
				diff = goal - cur;
				if (diff > limit)
					nxt = cur + limit;
				else if (diff < -limit)
					nxt = cur - limit;
				else
					nxt = goal;
				command_q[s] = nxt[VALUE_W-1:0];
				cmd.slot = SLOT_W'(s);
				cmd.command_position = nxt[VALUE_W-1:0];
				cmd.command_velocity = goal_vel[s];
				cmd.fade_weight = weight;
				cmd.final_command = (s == last_slot);
				queued_commands.push_back(cmd);
			end
		end
	endtask

	task automatic apply_item(input item_t it);
		logic enabled;
		enabled = regs.joint_enable_mask[it.joint];
		case (it.action)
		ACT_FEEDBACK: begin
			if (!initialized) begin
				if (enabled) begin
					command_q[it.joint] = it.position;
					goal_pos[it.joint] = it.position;
					goal_set[it.joint] = 1'b1;
				end
				if (it.final_feedback)
					initialized = 1'b1;
			end
		end
		ACT_TARGET: begin
			if (initialized) begin
				ticks_since = '0;
				if (enabled) begin
					goal_pos[it.joint] = it.position;
					goal_vel[it.joint] = it.velocity;
					goal_set[it.joint] = 1'b1;
				end
			end
		end
		ACT_TICK: begin
			if (initialized)
				ramp_tick();
		end
		default: ;
		endcase
	endtask

	task automatic check_command(input result_t got);
		result_t want;
		string where;
		if (queued_commands.size() == 0) begin
			report_mismatch("joint command with none pending, slot", got.slot, -1);
			return;
		end
		want = queued_commands.pop_front();
		compared++;
		where = $sformatf("slot %0d", want.slot);
		if (got.slot !== want.slot)
			report_mismatch({where, " slot"}, got.slot, want.slot);
		if (got.command_position !== want.command_position)
			report_mismatch({where, " command_position"},
				$signed(got.command_position), $signed(want.command_position));
		if (got.command_velocity !== want.command_velocity)
			report_mismatch({where, " command_velocity"},
				$signed(got.command_velocity), $signed(want.command_velocity));
		if (got.fade_weight !== want.fade_weight)
			report_mismatch({where, " fade_weight"}, got.fade_weight, want.fade_weight);
		if (got.final_command !== want.final_command)
			report_mismatch({where, " final_command"}, got.final_command,
				want.final_command);
	endtask

	// Results are taken before items: a tick accepted on this edge cannot have
	// produced a command that leaves on the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.joint_enable_mask = RST_ENABLE_MASK;
			regs.base_max_step = RST_BASE_STEP;
			regs.step_period = RST_STEP_PERIOD;
			regs.timeout_ticks = RST_TIMEOUT;
			regs.fade_increment = RST_FADE_INC;
			initialized = 1'b0;
			for (int s = 0; s < MAX_SLOTS; s++) begin
				command_q[s] = '0;
				goal_pos[s] = '0;
				goal_vel[s] = '0;
			end
			goal_set = '0;
			ticks_since = TICKS_MAX;
			weight = '0;
			queued_commands.delete();
		end else begin
			if (result_valid && result_ready)
				check_command(result);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_ENABLE_MASK: regs.joint_enable_mask = cfg_data[MASK_W-1:0];
				CFG_BASE_STEP: regs.base_max_step = cfg_data[BASE_W-1:0];
				CFG_STEP_PERIOD: regs.step_period = cfg_data[PERIOD_W-1:0];
				CFG_TIMEOUT: regs.timeout_ticks = cfg_data[TICK_W-1:0];
				CFG_FADE_INC: regs.fade_increment = cfg_data[PERIOD_W-1:0];
				default: ;
				endcase
			end
			if (item_valid && item_ready)
				apply_item(item);
		end
		mismatches <= error_total;
		outstanding <= queued_commands.size();
		commands_checked <= compared;
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the joint setpoint slew limiter
// Loads every joint once through the feedback path, then drives directed and
// random target and tick traffic under changing register settings, with
// random gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
	import jssl_pkg::*;

	// Action code 3 has no meaning; the block must drop such items.
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 312;
	localparam int PHASES = 8;
	// A tick walks 16 slots, so the settle pause covers a tick that is still
	// busy after its last command (or that has none).
	localparam int SETTLE_CYCLES = 100;
	// Longest quiet stretch of a correct run is a settle pause plus a result
	// stall plus a sender gap plus a tick.
	localparam int IDLE_LIMIT = 3000;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	int mismatches;
	int outstanding;
	int commands_checked;

	cfg_regs_t regs_now;
	bit steady_sender;
	int n_feedback = 0;
	int n_target = 0;
	int n_tick = 0;
	int n_ignored = 0;
	int n_settings = 0;

	joint_setpoint_slew_limiter_fade dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	jssl_checker ramp_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.commands_checked(commands_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic item_t make_item(input logic [1:0] action, input int joint,
		input logic [31:0] position, input logic [31:0] velocity, input logic last);
		item_t it;
		it.action = action;
		it.joint = SLOT_W'(joint);
		it.position = position;
		it.velocity = velocity;
		it.final_feedback = last;
		return it;
	endfunction

	// Mostly back-to-back or short gaps, now and then a long one. A steady
	// phase sends with no gaps at all.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady_sender || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Positions and velocities: small values keep ramps short enough to
	// reach their targets, full-range and extreme values stress the limiter.
	function automatic logic [31:0] rand_value(input bit zero_often);
		int roll;
		roll = $urandom_range(0, 9);
		if (zero_often && roll < 3)
			return '0;
		if (roll < 6)
			return 32'($urandom_range(0, 400000)) - 32'd200000;
		if (roll < 7)
			return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		return $urandom;
	endfunction

	// Register set for one random phase. The first two phases sit at the low
	// and high extremes of all registers but the enable mask (all ones in phase 0).
	function automatic cfg_regs_t pick_regs(input int phase);
		cfg_regs_t r;
		r.joint_enable_mask = (phase == 0 || $urandom_range(0, 4) == 0) ?
			16'hFFFF : 16'($urandom);
		r.base_max_step = $urandom_range(0, 1) ? 31'($urandom_range(0, 5000)) :
			31'($urandom);
		r.step_period = 17'($urandom_range(1, 65536));
		r.timeout_ticks = 16'($urandom_range(0, 30));
		r.fade_increment = 17'($urandom_range(1, 20000));
		case (phase)
		0: begin
			r.base_max_step = '0;
			r.step_period = 17'd1;
			r.timeout_ticks = '0;
			r.fade_increment = '0;
		end
		1: begin
			r.base_max_step = 31'h7FFF_FFFF;
			r.step_period = 17'h1_0000;
			r.timeout_ticks = 16'hFFFF;
			r.fade_increment = 17'h1_0000;
		end
		default: ;
		endcase
		return r;
	endfunction

	// Hold valid from the first cycle and keep the payload until the block
	// takes it. Valid is only lowered when a gap follows, so it never gets
	// two assignments in one time step.
	task automatic send(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		case (it.action)
		ACT_FEEDBACK: n_feedback++;
		ACT_TARGET: n_target++;
		ACT_TICK: n_tick++;
		default: n_ignored++;
		endcase
	endtask

	// Stop sending until every predicted command has left the block, then let
	// a possibly still running tick finish. The checker's count is updated on
	// the clock edge, so the task waits for an edge before it reads it.
	task automatic wait_quiet();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] data);
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all five registers back to back; only called while the block
	// is idle.
	task automatic write_regs(input cfg_regs_t r);
		cfg_valid <= 1'b1;
		put_reg(CFG_ENABLE_MASK, 32'(r.joint_enable_mask));
		put_reg(CFG_BASE_STEP, 32'(r.base_max_step));
		put_reg(CFG_STEP_PERIOD, 32'(r.step_period));
		put_reg(CFG_TIMEOUT, 32'(r.timeout_ticks));
		put_reg(CFG_FADE_INC, 32'(r.fade_increment));
		cfg_valid <= 1'b0;
		regs_now = r;
		n_settings++;
	endtask

	// Result side: long ready stretches, short and long stalls, so that
	// back-pressure stalls the emit step of the slot walk.
	initial begin
		int roll;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			roll = $urandom_range(0, 99);
			if (roll < 5) begin
				result_ready <= 1'b1;
				repeat ($urandom_range(100, 300)) @(posedge clk);
			end else if (roll < 55) begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (roll < 90) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				result_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// Watchdog: any transaction on any channel restarts the count.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int counted;
		int roll;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ENABLE_MASK;
		cfg_data <= '0;
		regs_now.joint_enable_mask = RST_ENABLE_MASK;
		regs_now.base_max_step = RST_BASE_STEP;
		regs_now.step_period = RST_STEP_PERIOD;
		regs_now.timeout_ticks = RST_TIMEOUT;
		regs_now.fade_increment = RST_FADE_INC;
		steady_sender = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before initialization nothing may happen: a tick, a target, an
		// unused action code and feedback for a slot that is not yet enabled
		// (the mask resets to zero) all leave the state untouched.
		send(make_item(ACT_TICK, 0, 32'd0, 32'd0, 1'b0));
		send(make_item(ACT_TARGET, 4, 32'd123, 32'd5, 1'b0));
		send(make_item(ACT_UNUSED, 7, $urandom, $urandom, 1'b1));
		send(make_item(ACT_FEEDBACK, 2, 32'd77, 32'd0, 1'b0));

		// Load every slot, with the position extremes on the first two. All
		// sixteen slots hold a command from here on, so no later target can
		// reach a slot whose command was never loaded.
		wait_quiet();
		regs_now.joint_enable_mask = 16'hFFFF;
		write_regs(regs_now);
		for (int j = 0; j < MAX_SLOTS; j++)
			send(make_item(ACT_FEEDBACK, j,
				(j == 0) ? 32'h7FFF_FFFF : (j == 1) ? 32'h8000_0000 :
				(j == 2) ? 32'd0 : rand_value(1'b0), $urandom, 1'b0));

		// The final feedback goes to a slot that is now disabled: the block
		// becomes initialized but slot 15 keeps its earlier value. Feedback
		// after that is dropped.
		wait_quiet();
		regs_now.joint_enable_mask = 16'h7FFF;
		write_regs(regs_now);
		send(make_item(ACT_FEEDBACK, 15, rand_value(1'b0), 32'd0, 1'b1));
		send(make_item(ACT_FEEDBACK, 0, 32'd0, 32'd0, 1'b1));

		// First tick: the counter is still saturated, so the weight ramps
		// down from zero and each slot repeats its loaded position.
		send(make_item(ACT_TICK, 0, 32'd0, 32'd0, 1'b0));
		// A target for a disabled slot only restarts the counter. Then the
		// two extreme slots are sent across the full range at full speed.
		send(make_item(ACT_TARGET, 15, 32'd0, 32'd0, 1'b0));
		send(make_item(ACT_TARGET, 0, 32'h8000_0000, 32'h8000_0000, 1'b0));
		send(make_item(ACT_TARGET, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		send(make_item(ACT_TICK, 0, 32'd0, 32'd0, 1'b0));
		send(make_item(ACT_TICK, 0, 32'd0, 32'd0, 1'b0));

		// No slot enabled: the weight and counter still move, no commands.
		wait_quiet();
		regs_now.joint_enable_mask = '0;
		write_regs(regs_now);
		send(make_item(ACT_TICK, 0, 32'd0, 32'd0, 1'b0));

		// Zero period drops the velocity term; a full-scale fade increment
		// must clamp the weight at one.
		wait_quiet();
		regs_now.joint_enable_mask = 16'hFFFF;
		regs_now.step_period = '0;
		regs_now.timeout_ticks = 16'hFFFF;
		regs_now.fade_increment = 17'h1_0000;
		write_regs(regs_now);
		send(make_item(ACT_TARGET, 2, 32'd1000000, 32'h7FFF_FFFF, 1'b0));
		send(make_item(ACT_TICK, 0, 32'd0, 32'd0, 1'b0));
		send(make_item(ACT_TICK, 0, 32'd0, 32'd0, 1'b0));

		// Random part: each phase gets a new register set, then mostly
		// targets and ticks with random content. Now and then the sender
		// waits for every command to drain, and a few dropped items (late
		// feedback, unused action) are mixed in without being counted.
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_quiet();
			write_regs(pick_regs(phase));
			steady_sender = (phase % 3 == 2);
			counted = 0;
			while (counted < RANDOM_ITEMS / PHASES) begin
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					wait_quiet();
				end else if (roll < 48) begin
					send(make_item(ACT_TARGET, $urandom_range(0, 15), rand_value(1'b0),
						rand_value(1'b1), $urandom_range(0, 1)));
					counted++;
				end else if (roll < 92) begin
					send(make_item(ACT_TICK, $urandom_range(0, 15), $urandom, $urandom,
						$urandom_range(0, 1)));
					counted++;
				end else begin
					send(make_item((roll < 96) ? ACT_FEEDBACK : ACT_UNUSED,
						$urandom_range(0, 15), $urandom, $urandom, $urandom_range(0, 1)));
				end
			end
		end
		steady_sender = 1'b0;

		wait_quiet();
		$display("Sent %0d feedback, %0d target, %0d tick and %0d unused-code items.",
			n_feedback, n_target, n_tick, n_ignored);
		$display("Compared %0d joint commands over %0d register settings.",
			commands_checked, n_settings);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
